@@ sv/template_to_script_transcoder_core_assert.svh @@
// Assertion macros shared by the transcoder modules.
`ifndef TEMPLATE_TO_SCRIPT_TRANSCODER_CORE_ASSERT_SVH
`define TEMPLATE_TO_SCRIPT_TRANSCODER_CORE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TTST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define TTST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ttst_pkg.sv @@
// Types, codes and text constants of the template-to-script transcoder.
package ttst_pkg;

    localparam int MAX_OUT = 12;

    // ASCII bytes used by the escaping rules
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;

    // Status codes carried on every result
    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // Leading string of a command
    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_PRINT,   // print "
        PRE_LEAVE    // "; 
    } pre_sel_t;

    // Fixed string after the raw bytes
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_EXPR_OPEN,   // print((
        TAIL_EXPR_CLOSE,  // )); 
        TAIL_STMT_CLOSE   // ; 
    } tail_sel_t;

    // Configuration registers
    typedef struct packed {
        logic [7:0] begin_first;
        logic [7:0] begin_second;
        logic [7:0] end_first;
        logic [7:0] end_second;
        logic [7:0] expression_mark;
        logic [7:0] comment_mark;
    } cfg_t;

    // One classified input word: output is pre, raw bytes, tail, escaped byte
    typedef struct packed {
        pre_sel_t   pre;
        logic [1:0] nraw;
        logic [7:0] raw0;
        logic [7:0] raw1;
        tail_sel_t  tail;
        logic       esc_en;
        logic [7:0] esc_char;
        logic [1:0] status;
    } cmd_t;

    function automatic logic [3:0] pre_len(input pre_sel_t sel);
        case (sel)
            PRE_PRINT: pre_len = 4'd7;
            PRE_LEAVE: pre_len = 4'd3;
            default:   pre_len = 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] pre_byte(input pre_sel_t sel, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (sel == PRE_LEAVE) begin
            case (idx)
                3'd0:    b = CH_QUOTE;
                3'd1:    b = 8'h3B;
                default: b = 8'h20;
            endcase
        end else begin
            case (idx)
                3'd0:    b = 8'h70;
                3'd1:    b = 8'h72;
                3'd2:    b = 8'h69;
                3'd3:    b = 8'h6E;
                3'd4:    b = 8'h74;
                3'd5:    b = 8'h20;
                default: b = CH_QUOTE;
            endcase
        end
        return b;
    endfunction

    function automatic logic [3:0] tail_len(input tail_sel_t sel);
        case (sel)
            TAIL_EXPR_OPEN:  tail_len = 4'd7;
            TAIL_EXPR_CLOSE: tail_len = 4'd4;
            TAIL_STMT_CLOSE: tail_len = 4'd2;
            default:         tail_len = 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] tail_byte(input tail_sel_t sel, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (sel)
            TAIL_EXPR_OPEN: begin
                case (idx)
                    3'd0:    b = 8'h70;
                    3'd1:    b = 8'h72;
                    3'd2:    b = 8'h69;
                    3'd3:    b = 8'h6E;
                    3'd4:    b = 8'h74;
                    default: b = 8'h28;
                endcase
            end
            TAIL_EXPR_CLOSE: begin
                case (idx)
                    3'd0, 3'd1: b = 8'h29;
                    3'd2:       b = 8'h3B;
                    default:    b = 8'h20;
                endcase
            end
            TAIL_STMT_CLOSE: b = (idx == 3'd0) ? 8'h3B : 8'h20;
            default:         b = 8'h00;
        endcase
        return b;
    endfunction

    // Length of a text byte after escaping
    function automatic logic [3:0] esc_len(input logic [7:0] c);
        if (c == CH_LF)
            esc_len = 4'd4;
        else if (c == CH_TAB || c == CH_BSLASH || c == CH_QUOTE || c == CH_HASH)
            esc_len = 4'd2;
        else
            esc_len = 4'd1;
    endfunction

    function automatic logic [7:0] esc_byte(input logic [7:0] c, input logic [1:0] idx);
        logic [7:0] b;
        b = c;
        if (c == CH_LF) begin
            case (idx)
                2'd0:    b = CH_BSLASH;
                2'd1:    b = 8'h6E;
                2'd2:    b = CH_QUOTE;
                default: b = CH_LF;
            endcase
        end else if (c == CH_TAB) begin
            b = (idx == 2'd0) ? CH_BSLASH : 8'h74;
        end else if (c == CH_BSLASH || c == CH_QUOTE || c == CH_HASH) begin
            b = (idx == 2'd0) ? CH_BSLASH : c;
        end
        return b;
    endfunction

endpackage

@@ sv/ttst_front.sv @@
// Front end: parses template words and turns each into one output command.
`include "template_to_script_transcoder_core_assert.svh"

module ttst_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  ttst_pkg::cfg_t    cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,   // end_of_input
    input  logic              q_full,
    output logic              q_push,
    output ttst_pkg::cmd_t    q_cmd
);

    localparam logic [1:0] MODE_TEXT     = 2'd0;
    localparam logic [1:0] MODE_AFTER_B1 = 2'd1;
    localparam logic [1:0] MODE_PAIR     = 2'd2;
    localparam logic [1:0] MODE_CODE     = 2'd3;

    localparam logic [1:0] KIND_STMT    = 2'd0;
    localparam logic [1:0] KIND_EXPR    = 2'd1;
    localparam logic [1:0] KIND_COMMENT = 2'd2;

    logic [1:0] mode_reg, mode_next;
    logic       so_reg, so_next;
    logic [1:0] kind_reg, kind_next;
    logic [1:0] prev_reg, prev_next;
    logic       pend_reg, pend_next;

    logic       accept;
    logic [7:0] c;
    logic       c_is_bf, c_is_bs, c_is_ef, c_is_es, c_is_em, c_is_cm, c_is_lf;
    logic [1:0] class_c, class_ef;
    logic       emit_ef, emit_c;
    ttst_pkg::pre_sel_t open_pre;
    ttst_pkg::cmd_t     cmd;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !q_full;
    assign q_push   = accept;
    assign q_cmd    = cmd;

    assign c       = s_tdata;
    assign c_is_bf = (c == cfg.begin_first);
    assign c_is_bs = (c == cfg.begin_second);
    assign c_is_ef = (c == cfg.end_first);
    assign c_is_es = (c == cfg.end_second);
    assign c_is_em = (c == cfg.expression_mark);
    assign c_is_cm = (c == cfg.comment_mark);
    assign c_is_lf = (c == ttst_pkg::CH_LF);

    // class bits: bit0 = LF, bit1 = end_first
    assign class_c  = {c_is_ef, c_is_lf};
    assign class_ef = {1'b1, cfg.end_first == ttst_pkg::CH_LF};

    // opening a print string only when none is open
    assign open_pre = so_reg ? ttst_pkg::PRE_NONE : ttst_pkg::PRE_PRINT;

    assign emit_ef = (kind_reg != KIND_COMMENT);
    assign emit_c  = !c_is_ef && (c_is_lf || kind_reg != KIND_COMMENT);

    // classify the word and compute the next parser state
    always_comb begin
        cmd       = '0;
        cmd.status = ttst_pkg::ST_RUN;
        mode_next = mode_reg;
        so_next   = so_reg;
        kind_next = kind_reg;
        prev_next = prev_reg;
        pend_next = pend_reg;

        if (s_tlast) begin
            case (mode_reg)
                MODE_TEXT: begin
                    if (so_reg) begin
                        cmd.nraw = 2'd1;
                        cmd.raw0 = ttst_pkg::CH_QUOTE;
                    end
                    cmd.status = ttst_pkg::ST_OK;
                end
                MODE_AFTER_B1: begin
                    cmd.pre    = open_pre;
                    cmd.nraw   = 2'd2;
                    cmd.raw0   = cfg.begin_first;
                    cmd.raw1   = ttst_pkg::CH_QUOTE;
                    cmd.status = ttst_pkg::ST_OK;
                end
                default: cmd.status = ttst_pkg::ST_MISSING;
            endcase
            mode_next = MODE_TEXT;
            so_next   = 1'b0;
            kind_next = KIND_STMT;
            prev_next = 2'd0;
            pend_next = 1'b0;
        end else begin
            case (mode_reg)
                MODE_TEXT: begin
                    if (c_is_bf) begin
                        mode_next = MODE_AFTER_B1;
                    end else begin
                        cmd.pre      = open_pre;
                        cmd.esc_en   = 1'b1;
                        cmd.esc_char = c;
                        so_next      = !c_is_lf;
                    end
                end
                MODE_AFTER_B1: begin
                    if (c_is_bs) begin
                        mode_next = MODE_PAIR;
                    end else begin
                        // lone begin_first goes out raw, this byte is fresh text or a new begin_first
                        cmd.pre  = open_pre;
                        cmd.nraw = 2'd1;
                        cmd.raw0 = cfg.begin_first;
                        if (c_is_bf) begin
                            mode_next = MODE_AFTER_B1;
                            so_next   = 1'b1;
                        end else begin
                            mode_next    = MODE_TEXT;
                            cmd.esc_en   = 1'b1;
                            cmd.esc_char = c;
                            so_next      = !c_is_lf;
                        end
                    end
                end
                MODE_PAIR: begin
                    if (c_is_bs) begin
                        // doubled begin_second is a literal marker
                        cmd.pre   = open_pre;
                        cmd.nraw  = 2'd2;
                        cmd.raw0  = cfg.begin_first;
                        cmd.raw1  = cfg.begin_second;
                        mode_next = MODE_TEXT;
                        so_next   = 1'b1;
                    end else begin
                        cmd.pre   = so_reg ? ttst_pkg::PRE_LEAVE : ttst_pkg::PRE_NONE;
                        so_next   = 1'b0;
                        mode_next = MODE_CODE;
                        prev_next = 2'd0;
                        pend_next = 1'b0;
                        if (c_is_cm) begin
                            kind_next = KIND_COMMENT;
                        end else if (c_is_em) begin
                            kind_next = KIND_EXPR;
                            cmd.tail  = ttst_pkg::TAIL_EXPR_OPEN;
                        end else begin
                            kind_next = KIND_STMT;
                            if (c_is_ef) begin
                                pend_next = 1'b1;
                            end else begin
                                cmd.nraw  = 2'd1;
                                cmd.raw0  = c;
                                prev_next = class_c;
                            end
                        end
                    end
                end
                default: begin
                    if (pend_reg) begin
                        pend_next = 1'b0;
                        if (c_is_es) begin
                            // section closes
                            if (kind_reg == KIND_EXPR)
                                cmd.tail = ttst_pkg::TAIL_EXPR_CLOSE;
                            else if (kind_reg == KIND_STMT && !prev_reg[0])
                                cmd.tail = ttst_pkg::TAIL_STMT_CLOSE;
                            mode_next = MODE_TEXT;
                            so_next   = 1'b0;
                        end else begin
                            // literal end_first, then this byte as code
                            cmd.nraw  = {1'b0, emit_ef} + {1'b0, emit_c};
                            cmd.raw0  = emit_ef ? cfg.end_first : c;
                            cmd.raw1  = c;
                            prev_next = c_is_ef ? class_ef : class_c;
                        end
                    end else begin
                        if (c_is_ef) begin
                            if (!prev_reg[1])
                                pend_next = 1'b1;
                        end else begin
                            if (emit_c) begin
                                cmd.nraw = 2'd1;
                                cmd.raw0 = c;
                            end
                            prev_next = class_c;
                        end
                    end
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TEXT;
            so_reg   <= 1'b0;
            kind_reg <= KIND_STMT;
            prev_reg <= 2'd0;
            pend_reg <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            so_reg   <= so_next;
            kind_reg <= kind_next;
            prev_reg <= prev_next;
            pend_reg <= pend_next;
        end
    end

    `TTST_ASSERT(pend_only_in_code, pend_reg |-> (mode_reg == MODE_CODE),
                 "pending end_first outside a code section")
    `TTST_ASSERT_NEXT(eoi_clears_state, accept && s_tlast,
                      mode_reg == MODE_TEXT && !so_reg && !pend_reg && prev_reg == 2'd0,
                      "state not cleared after end of input")
    `TTST_ASSERT(string_closed_in_code, (mode_reg == MODE_CODE) |-> !so_reg,
                 "print string open inside a code section")

endmodule

@@ sv/ttst_cmdq.sv @@
// Command queue between the parser and the byte serializer.
`include "template_to_script_transcoder_core_assert.svh"

module ttst_cmdq #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ttst_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ttst_pkg::cmd_t  head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ttst_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    `TTST_ASSERT(count_in_range, count_reg <= CW'(DEPTH), "queue count beyond depth")
    `TTST_ASSERT(pop_needs_entry, pop |-> (count_reg != '0), "pop from an empty queue")

endmodule

@@ sv/ttst_back.sv @@
// Back end: expands queued commands into output bytes, one word per cycle while the output is ready.
`include "template_to_script_transcoder_core_assert.svh"

module ttst_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  ttst_pkg::cmd_t  head_cmd,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [2:0]      m_tuser,   // [0] byte_valid, [2:1] status
    output logic            m_tlast    // last_of_run
);

    logic [3:0] pos_reg, pos_next;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic [2:0] user_reg;
    logic       last_reg;

    logic       advance;
    logic [3:0] b1, b2, b3, total, le;
    logic [3:0] off_raw, off_tail, off_esc;
    logic       is_empty, is_last;
    logic [7:0] byte_sel;

    // segment boundaries of the current command
    assign b1      = ttst_pkg::pre_len(head_cmd.pre);
    assign b2      = b1 + {2'b00, head_cmd.nraw};
    assign b3      = b2 + ttst_pkg::tail_len(head_cmd.tail);
    assign le      = head_cmd.esc_en ? ttst_pkg::esc_len(head_cmd.esc_char) : 4'd0;
    assign total   = b3 + le;
    assign off_raw = pos_reg - b1;
    assign off_tail = pos_reg - b2;
    assign off_esc = pos_reg - b3;

    assign is_empty = (total == 4'd0);
    assign is_last  = is_empty || (pos_reg == total - 4'd1);

    assign advance = head_valid && (!valid_reg || m_tready);
    assign pop     = advance && is_last;

    // byte at the current position
    always_comb begin
        if (is_empty)
            byte_sel = 8'h00;
        else if (pos_reg < b1)
            byte_sel = ttst_pkg::pre_byte(head_cmd.pre, pos_reg[2:0]);
        else if (pos_reg < b2)
            byte_sel = (off_raw == 4'd0) ? head_cmd.raw0 : head_cmd.raw1;
        else if (pos_reg < b3)
            byte_sel = ttst_pkg::tail_byte(head_cmd.tail, off_tail[2:0]);
        else
            byte_sel = ttst_pkg::esc_byte(head_cmd.esc_char, off_esc[1:0]);
    end

    always_comb begin
        pos_next = pos_reg;
        if (advance)
            pos_next = is_last ? 4'd0 : pos_reg + 4'd1;
    end

    // position counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (advance)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= byte_sel;
            user_reg <= {head_cmd.status, !is_empty};
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    `TTST_ASSERT(pos_in_range, pos_reg < 4'(ttst_pkg::MAX_OUT), "byte position out of range")
    `TTST_ASSERT(empty_word_alone, (m_tvalid && !m_tuser[0]) |-> m_tlast,
                 "empty result word is not the last of its run")

endmodule

@@ sv/template_to_script_transcoder_core.sv @@
// Top level of the template-to-script transcoder: config registers, parser, queue, serializer.
//
// Template bytes enter on the s_ stream, one word per cycle, as long as the command queue
// has room; each word is parsed combinationally and leaves a command in a QUEUE_DEPTH-entry
// queue. The serializer expands each command into 1 to 12 result words on the m_ stream at
// one word per clock while m_tready allows, so the sustained rate is set by the output byte
// count: a command stays at the queue head until all its result words have left (a single
// empty word for one that makes no byte). An accepted item is held in a queue entry, and its
// result words leave the output word register. Configuration registers sit on the APB
// port at byte addresses 0, 4, .., 20 and are to be written only while the block is idle.
module template_to_script_transcoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // template stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // end_of_input
    // script stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic [2:0]  m_tuser,    // [0] byte_valid, [2:1] status
    output logic        m_tlast     // last_of_run
);

    localparam logic [2:0] REG_BEGIN_FIRST  = 3'd0;
    localparam logic [2:0] REG_BEGIN_SECOND = 3'd1;
    localparam logic [2:0] REG_END_FIRST    = 3'd2;
    localparam logic [2:0] REG_END_SECOND   = 3'd3;
    localparam logic [2:0] REG_EXPR_MARK    = 3'd4;
    localparam logic [2:0] REG_COMMENT_MARK = 3'd5;

    ttst_pkg::cfg_t cfg_reg;
    logic           cfg_write;
    logic [2:0]     reg_idx;

    logic           q_push, q_full, q_pop, q_head_valid;
    ttst_pkg::cmd_t q_push_cmd, q_head_cmd;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.begin_first     <= 8'd60;
            cfg_reg.begin_second    <= 8'd37;
            cfg_reg.end_first       <= 8'd37;
            cfg_reg.end_second      <= 8'd62;
            cfg_reg.expression_mark <= 8'd61;
            cfg_reg.comment_mark    <= 8'd35;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_BEGIN_FIRST:  cfg_reg.begin_first     <= pwdata[7:0];
                REG_BEGIN_SECOND: cfg_reg.begin_second    <= pwdata[7:0];
                REG_END_FIRST:    cfg_reg.end_first       <= pwdata[7:0];
                REG_END_SECOND:   cfg_reg.end_second      <= pwdata[7:0];
                REG_EXPR_MARK:    cfg_reg.expression_mark <= pwdata[7:0];
                REG_COMMENT_MARK: cfg_reg.comment_mark    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            REG_BEGIN_FIRST:  prdata = {24'd0, cfg_reg.begin_first};
            REG_BEGIN_SECOND: prdata = {24'd0, cfg_reg.begin_second};
            REG_END_FIRST:    prdata = {24'd0, cfg_reg.end_first};
            REG_END_SECOND:   prdata = {24'd0, cfg_reg.end_second};
            REG_EXPR_MARK:    prdata = {24'd0, cfg_reg.expression_mark};
            REG_COMMENT_MARK: prdata = {24'd0, cfg_reg.comment_mark};
            default:          prdata = 32'd0;
        endcase
    end

    ttst_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    ttst_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    ttst_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
